### sv/stsum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsum_pkg
// Shared types and constants for the segment tree range sum block.
// ----------------------------------------------------------------------------
package stsum_pkg;

	localparam int LEAVES    = 1024;
	localparam int LEAF_W    = 10;            // log2(LEAVES)
	localparam int MEM_DEPTH = 2 * LEAVES;
	localparam int MEM_AW    = LEAF_W + 1;    // node index 1 .. 2*LEAVES-1
	localparam int NODE_W    = LEAF_W + 2;    // also holds the upper bound 2*LEAVES
	localparam int VAL_W     = 32;
	localparam int SUM_W     = 48;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [MEM_AW-1:0] addr_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// one write and one read per cycle into the node store
	typedef struct packed {
		logic  we;
		addr_t waddr;
		sum_t  wdata;
		addr_t raddr;
	} mem_req_t;

endpackage

### sv/stsum_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsum_mem
// Node sum store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stsum_mem (
	input  logic                clk,
	input  stsum_pkg::mem_req_t req,
	output stsum_pkg::sum_t     rd_data
);

	stsum_pkg::sum_t mem_q [stsum_pkg::MEM_DEPTH];
	stsum_pkg::sum_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem_q[req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

### sv/stsum_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsum_seq
// Sequencer for the tree walks, with the shared 48-bit adder.
// ----------------------------------------------------------------------------
module stsum_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                opcode,
	input  logic [stsum_pkg::LEAF_W-1:0]        position,
	input  logic signed [stsum_pkg::VAL_W-1:0]  value,
	input  logic [stsum_pkg::LEAF_W-1:0]        range_left,
	input  logic [stsum_pkg::LEAF_W:0]          range_right,
	output stsum_pkg::sum_t                     sum,
	output logic                                done,
	output stsum_pkg::mem_req_t                 mem_req,
	input  stsum_pkg::sum_t                     rd_data
);

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_UP       = 3'd2;
	localparam logic [2:0] ST_UP_ADD   = 3'd3;
	localparam logic [2:0] ST_Q_LO     = 3'd4;
	localparam logic [2:0] ST_Q_LO_ADD = 3'd5;
	localparam logic [2:0] ST_Q_HI     = 3'd6;
	localparam logic [2:0] ST_Q_HI_ADD = 3'd7;

	localparam logic [stsum_pkg::LEAF_W:0] LEAVES_R = (stsum_pkg::LEAF_W + 1)'(stsum_pkg::LEAVES);
	localparam logic [stsum_pkg::NODE_W-1:0] LEAVES_N = stsum_pkg::NODE_W'(stsum_pkg::LEAVES);
	localparam logic [stsum_pkg::NODE_W-1:0] ROOT_N = stsum_pkg::NODE_W'(1);

	logic [2:0]                       state_q;
	stsum_pkg::addr_t                 clr_q;
	logic                             done_q;
	logic [stsum_pkg::NODE_W-1:0]     lo_q;   // also the node on a set walk
	logic [stsum_pkg::NODE_W-1:0]     hi_q;
	stsum_pkg::sum_t                  acc_q;  // running sum, or path value on a set
	stsum_pkg::sum_t                  sum_q;

	logic                             accept;
	logic [stsum_pkg::LEAF_W:0]       right_c;
	logic                             empty;
	logic [stsum_pkg::NODE_W-1:0]     hi_dec;
	stsum_pkg::sum_t                  add_res;

	assign accept  = start && (state_q == ST_IDLE);
	assign right_c = (range_right > LEAVES_R) ? LEAVES_R : range_right;
	assign empty   = ({1'b0, range_left} >= right_c);
	assign hi_dec  = hi_q - ROOT_N;
	assign add_res = acc_q + rd_data;

	always_comb begin
		mem_req       = '0;
		mem_req.waddr = lo_q[stsum_pkg::MEM_AW-1:0];
		mem_req.wdata = acc_q;
		case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = '0;
			end
			ST_UP: begin
				// store this node, fetch its sibling
				mem_req.we    = 1'b1;
				mem_req.raddr = lo_q[stsum_pkg::MEM_AW-1:0] ^ stsum_pkg::MEM_AW'(1);
			end
			ST_Q_LO: begin
				mem_req.raddr = lo_q[stsum_pkg::MEM_AW-1:0];
			end
			ST_Q_HI: begin
				mem_req.raddr = hi_dec[stsum_pkg::MEM_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + stsum_pkg::MEM_AW'(1);
					if (clr_q == stsum_pkg::MEM_AW'(stsum_pkg::MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (opcode == stsum_pkg::OP_SET) begin
							state_q <= ST_UP;
						end else if (empty) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_Q_LO;
						end
					end
				end
				ST_UP: begin
					state_q <= (lo_q == ROOT_N) ? ST_IDLE : ST_UP_ADD;
				end
				ST_UP_ADD: begin
					state_q <= ST_UP;
				end
				ST_Q_LO: begin
					if (lo_q >= hi_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (lo_q[0]) begin
						state_q <= ST_Q_LO_ADD;
					end else begin
						state_q <= ST_Q_HI;
					end
				end
				ST_Q_LO_ADD: begin
					state_q <= ST_Q_HI;
				end
				ST_Q_HI: begin
					state_q <= hi_q[0] ? ST_Q_HI_ADD : ST_Q_LO;
				end
				ST_Q_HI_ADD: begin
					state_q <= ST_Q_LO;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode == stsum_pkg::OP_SET) begin
						lo_q  <= LEAVES_N + stsum_pkg::NODE_W'(position);
						acc_q <= stsum_pkg::SUM_W'(value);
					end else begin
						lo_q  <= LEAVES_N + stsum_pkg::NODE_W'(range_left);
						hi_q  <= LEAVES_N + stsum_pkg::NODE_W'(right_c);
						acc_q <= '0;
						sum_q <= '0;
					end
				end
			end
			ST_UP_ADD: begin
				acc_q <= add_res;
				lo_q  <= lo_q >> 1;
			end
			ST_Q_LO: begin
				if (lo_q >= hi_q) begin
					sum_q <= acc_q;
				end
			end
			ST_Q_LO_ADD: begin
				acc_q <= add_res;
				lo_q  <= lo_q + ROOT_N;
			end
			ST_Q_HI: begin
				if (hi_q[0]) begin
					hi_q <= hi_dec;
				end else begin
					lo_q <= lo_q >> 1;
					hi_q <= hi_q >> 1;
				end
			end
			ST_Q_HI_ADD: begin
				acc_q <= add_res;
				lo_q  <= lo_q >> 1;
				hi_q  <= hi_q >> 1;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign sum  = sum_q;

endmodule

### sv/segment_tree_range_sum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum_top
// Segment tree over 1024 leaves: point set and half-open range sum.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low.
// opcode OP_SET writes value into leaf position and updates the path to the
// root; it gives no result. opcode OP_QUERY sums leaves in
// [range_left, range_right), range_right clamped to the leaf count, and
// shows the sum for one cycle with done high. The receiver cannot stall.
// A set walks up from the leaf with one sibling read and one add per level.
// A query walks about 11 levels, passing ST_Q_LO and ST_Q_HI on each and
// an add state after either one whose bound is odd; done comes on the edge
// that returns busy low. An empty range answers 0 in the next cycle, with
// no walk. The pace is set by the single read port of the node store and
// the one shared 48-bit adder. Every request is one at a time.
// After reset a clearing pass zeroes all 2048 nodes, one per cycle; busy
// stays high until that pass ends.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                opcode,
	input  logic [stsum_pkg::LEAF_W-1:0]        position,
	input  logic signed [stsum_pkg::VAL_W-1:0]  value,
	input  logic [stsum_pkg::LEAF_W-1:0]        range_left,
	input  logic [stsum_pkg::LEAF_W:0]          range_right,
	output logic signed [stsum_pkg::SUM_W-1:0]  sum,
	output logic                                done
);

	stsum_pkg::mem_req_t mem_req;
	stsum_pkg::sum_t     rd_data;

	stsum_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.position    (position),
		.value       (value),
		.range_left  (range_left),
		.range_right (range_right),
		.sum         (sum),
		.done        (done),
		.mem_req     (mem_req),
		.rd_data     (rd_data)
	);

	stsum_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

endmodule

### tb/sv/segment_tree_range_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum_checker
// Keeps its own copy of the node sums and checks every range sum result.
// ----------------------------------------------------------------------------
// Watches the request and result ports of the range sum block. Each accepted
// set updates the local tree; each accepted query queues the sum it should
// give. Every result strobe is compared with the oldest queued sum.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic                                opcode,
	input  logic [stsum_pkg::LEAF_W-1:0]        position,
	input  logic signed [stsum_pkg::VAL_W-1:0]  value,
	input  logic [stsum_pkg::LEAF_W-1:0]        range_left,
	input  logic [stsum_pkg::LEAF_W:0]          range_right,
	input  logic signed [stsum_pkg::SUM_W-1:0]  sum,
	input  logic                                done,
	output int                                  fail_count,
	output int                                  pending_count
);

	stsum_pkg::sum_t node_sum [stsum_pkg::MEM_DEPTH];
	stsum_pkg::sum_t expected_sums [$];

	function automatic void write_leaf(input logic [stsum_pkg::LEAF_W-1:0] leaf,
		input logic signed [stsum_pkg::VAL_W-1:0] val);
		int node;
		node = stsum_pkg::LEAVES + int'(leaf);
		node_sum[stsum_pkg::MEM_AW'(node)] = stsum_pkg::SUM_W'(val);
		while (node > 1) begin
			node = node >> 1;
			node_sum[stsum_pkg::MEM_AW'(node)] = node_sum[stsum_pkg::MEM_AW'(2 * node)]
				+ node_sum[stsum_pkg::MEM_AW'(2 * node + 1)];
		end
	endfunction

	function automatic stsum_pkg::sum_t range_total(
		input logic [stsum_pkg::LEAF_W-1:0] lft,
		input logic [stsum_pkg::LEAF_W:0] rgt);
		int lo;
		int hi;
		stsum_pkg::sum_t acc;
		acc = '0;
		lo = int'(lft);
		hi = int'(rgt);
		if (hi > stsum_pkg::LEAVES)
			hi = stsum_pkg::LEAVES;
		if (lo >= hi)
			return acc;
		lo += stsum_pkg::LEAVES;
		hi += stsum_pkg::LEAVES;
		// both bounds climb together, taking the nodes just inside each
		while (lo < hi) begin
			if (lo[0]) begin
				acc += node_sum[stsum_pkg::MEM_AW'(lo)];
				lo++;
			end
			if (hi[0]) begin
				hi--;
				acc += node_sum[stsum_pkg::MEM_AW'(hi)];
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		stsum_pkg::sum_t want;
		if (!arst_n) begin
			foreach (node_sum[i])
				node_sum[i] = '0;
			expected_sums.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			// a result at this edge belongs to an earlier request
			if (done) begin
				if (expected_sums.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: result with no query pending, sum %0d", sum);
				end else begin
					want = expected_sums.pop_front();
					if (sum !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR: sum mismatch, expected %0d got %0d", want, sum);
					end
				end
			end
			if (start && !busy) begin
				if (opcode == stsum_pkg::OP_SET)
					write_leaf(position, value);
				else
					expected_sums.push_back(range_total(range_left, range_right));
			end
			pending_count = expected_sums.size();
		end
	end

endmodule

### tb/sv/segment_tree_range_sum_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum_top_tb
// Stimulus and verdict for the segment tree range sum block.
// ----------------------------------------------------------------------------
// Directed sets and queries on the edge leaves, full, empty, inverted and
// clamped ranges, then random mixes of sets and queries in three phases of
// sender idling. Prediction and comparison live in the checker instance.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_top_tb;

	localparam int STALL_LIMIT     = 20000;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int TAIL_CYCLES     = 60;
	localparam int RGT_W           = stsum_pkg::LEAF_W + 1;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic                                opcode;
	logic [stsum_pkg::LEAF_W-1:0]        position;
	logic signed [stsum_pkg::VAL_W-1:0]  value;
	logic [stsum_pkg::LEAF_W-1:0]        range_left;
	logic [stsum_pkg::LEAF_W:0]          range_right;
	logic signed [stsum_pkg::SUM_W-1:0]  sum;
	logic                                done;

	int fail_count;
	int pending_count;
	int sender_idle;
	int stall_cycles;

	segment_tree_range_sum_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.position    (position),
		.value       (value),
		.range_left  (range_left),
		.range_right (range_right),
		.sum         (sum),
		.done        (done)
	);

	segment_tree_range_sum_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.position      (position),
		.value         (value),
		.range_left    (range_left),
		.range_right   (range_right),
		.sum           (sum),
		.done          (done),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// drive one request at a falling edge, hold it until taken
	task automatic send_request(input logic op, input logic [stsum_pkg::LEAF_W-1:0] pos,
		input logic signed [stsum_pkg::VAL_W-1:0] val,
		input logic [stsum_pkg::LEAF_W-1:0] lft, input logic [stsum_pkg::LEAF_W:0] rgt);
		@(negedge clk);
		if ($urandom_range(0, 99) < sender_idle) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
		start       <= 1'b1;
		opcode      <= op;
		position    <= pos;
		value       <= val;
		range_left  <= lft;
		range_right <= rgt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic signed [stsum_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return -32'sd1;
			3: return $signed($urandom_range(0, 20)) - 10;
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic logic [stsum_pkg::LEAF_W-1:0] pick_leaf();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return stsum_pkg::LEAF_W'(stsum_pkg::LEAVES - 1);
			default: return stsum_pkg::LEAF_W'($urandom_range(0, stsum_pkg::LEAVES - 1));
		endcase
	endfunction

	task automatic random_item();
		logic [stsum_pkg::LEAF_W-1:0] lft;
		logic [stsum_pkg::LEAF_W:0]   rgt;
		if ($urandom_range(0, 99) < 45) begin
			send_request(stsum_pkg::OP_SET, pick_leaf(), pick_value(),
				stsum_pkg::LEAF_W'($urandom()), RGT_W'($urandom()));
		end else begin
			case ($urandom_range(0, 9))
				0: begin
					lft = stsum_pkg::LEAF_W'($urandom());
					rgt = RGT_W'(lft);
				end
				1: begin
					lft = stsum_pkg::LEAF_W'($urandom_range(1, stsum_pkg::LEAVES - 1));
					rgt = RGT_W'($urandom_range(0, lft - 1));
				end
				2: begin
					lft = stsum_pkg::LEAF_W'($urandom());
					rgt = RGT_W'($urandom_range(stsum_pkg::LEAVES + 1,
						2 * stsum_pkg::LEAVES - 1));
				end
				3: begin
					lft = '0;
					rgt = RGT_W'(stsum_pkg::LEAVES);
				end
				4, 5: begin
					lft = stsum_pkg::LEAF_W'($urandom());
					rgt = RGT_W'(lft + $urandom_range(1, 8));
				end
				default: begin
					lft = stsum_pkg::LEAF_W'($urandom_range(0, stsum_pkg::LEAVES - 2));
					rgt = RGT_W'($urandom_range(lft + 1, stsum_pkg::LEAVES));
				end
			endcase
			send_request(stsum_pkg::OP_QUERY, stsum_pkg::LEAF_W'($urandom()),
				$signed($urandom()), lft, rgt);
		end
	endtask

	// watchdog on cycles where neither a request nor a result moves
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = stsum_pkg::OP_SET;
		position    = '0;
		value       = '0;
		range_left  = '0;
		range_right = '0;
		sender_idle = 8;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: edge leaves, extreme values, special ranges
		send_request(stsum_pkg::OP_QUERY, '0, '0, '0, RGT_W'(stsum_pkg::LEAVES));
		send_request(stsum_pkg::OP_SET, '0, 32'sh7FFF_FFFF, '0, '0);
		send_request(stsum_pkg::OP_SET, 10'd1023, 32'sh8000_0000, 10'd1023, 11'h7FF);
		send_request(stsum_pkg::OP_SET, 10'd512, -32'sd1, '0, '0);
		send_request(stsum_pkg::OP_SET, 10'd1, 32'sh5555_5555,
			stsum_pkg::LEAF_W'($urandom()), RGT_W'($urandom()));
		send_request(stsum_pkg::OP_SET, 10'd1022, 32'shAAAA_AAAA,
			stsum_pkg::LEAF_W'($urandom()), RGT_W'($urandom()));
		send_request(stsum_pkg::OP_SET, 10'd2, 32'sh7FFF_FFFF, '0, '0);
		send_request(stsum_pkg::OP_SET, 10'd3, 32'sh7FFF_FFFF, '0, '0);
		send_request(stsum_pkg::OP_QUERY, stsum_pkg::LEAF_W'($urandom()),
			$signed($urandom()), '0, RGT_W'(stsum_pkg::LEAVES));
		send_request(stsum_pkg::OP_QUERY, '0, '0, '0, 11'd1);
		send_request(stsum_pkg::OP_QUERY, '0, '0, 10'd1023, RGT_W'(stsum_pkg::LEAVES));
		send_request(stsum_pkg::OP_QUERY, '0, '0, '0, 11'd512);
		send_request(stsum_pkg::OP_QUERY, '0, '0, 10'd512, RGT_W'(stsum_pkg::LEAVES));
		send_request(stsum_pkg::OP_QUERY, stsum_pkg::LEAF_W'($urandom()),
			$signed($urandom()), 10'd1, 11'd1023);
		send_request(stsum_pkg::OP_QUERY, '0, '0, 10'd7, 11'd7);
		send_request(stsum_pkg::OP_QUERY, '0, '0, 10'd900, 11'd100);
		send_request(stsum_pkg::OP_QUERY, '0, '0, 10'd1023, 11'd0);
		send_request(stsum_pkg::OP_QUERY, '0, '0, 10'd1023, 11'h7FF);
		send_request(stsum_pkg::OP_QUERY, '0, '0, '0, 11'h7FF);
		send_request(stsum_pkg::OP_SET, '0, 32'sh8000_0000, 10'h3FF, 11'h7FF);
		send_request(stsum_pkg::OP_SET, 10'd1023, '0, '0, '0);
		send_request(stsum_pkg::OP_QUERY, 10'h3FF, 32'sh7FFF_FFFF, '0, 11'd2);
		send_request(stsum_pkg::OP_QUERY, '0, '0, 10'd511, 11'd514);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: sender_idle = 8;
				1: sender_idle = 55;
				default: sender_idle = 0;
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				random_item();
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
sv/stsum_pkg.sv
sv/stsum_mem.sv
sv/stsum_seq.sv
sv/segment_tree_range_sum_top.sv
tb/sv/segment_tree_range_sum_checker.sv
tb/sv/segment_tree_range_sum_top_tb.sv
